/* hw/rtl/tdip_pkg.sv */
// ============================================================================
// tdip_pkg: shared types and constants of the two-digit ID text parser
// Character classes, recognizer codes and sizes used by the front end,
// the queue and the recognizer back end.
// ============================================================================
package tdip_pkg;

    // Run length of recognizer characters at which a string counts as too long.
    localparam int MAX_LEN     = 5;
    localparam int BLANK_LIMIT = 2 * MAX_LEN;
    localparam int CNT_W       = $clog2(2 * MAX_LEN + 2);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // ASCII codes used by the classifier.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UD    = 8'h44;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_UH    = 8'h48;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LD    = 8'h64;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_LH    = 8'h68;
    localparam logic [7:0] CH_LX    = 8'h78;

    // Format hint register codes.
    localparam logic [1:0] HINT_FREE = 2'd0;
    localparam logic [1:0] HINT_HEX  = 2'd1;
    localparam logic [1:0] HINT_DEC  = 2'd2;

    // Result status codes.
    localparam logic [3:0] STATUS_GOOD        = 4'd0;
    localparam logic [3:0] STATUS_BLANKS_ONLY = 4'd1;
    localparam logic [3:0] STATUS_BAD_CHAR1   = 4'd2;
    localparam logic [3:0] STATUS_BAD_CHAR2   = 4'd3;
    localparam logic [3:0] STATUS_BAD_DIGIT1  = 4'd4;
    localparam logic [3:0] STATUS_BAD_DIGIT2  = 4'd5;
    localparam logic [3:0] STATUS_TOO_MANY    = 4'd6;
    localparam logic [3:0] STATUS_BAD_SUFFIX  = 4'd7;
    localparam logic [3:0] STATUS_PRE_AND_SUF = 4'd8;
    localparam logic [3:0] STATUS_HEX_DEC1    = 4'd9;
    localparam logic [3:0] STATUS_HEX_DEC2    = 4'd10;
    localparam logic [3:0] STATUS_NO_DIGITS   = 4'd11;

    // One classified character as it travels from front end to back end.
    typedef struct packed {
        logic       term;   // terminator code
        logic       blank;  // space or tab
        logic       zero;   // the digit zero
        logic       dig;    // decimal digit
        logic       hexl;   // hex letter a-f or A-F
        logic       is_x;
        logic       is_h;
        logic       is_d;
        logic [3:0] nib;    // digit value, zero when not a hex digit
    } char_class_t;

    typedef struct packed {
        logic       empty;
        logic [3:0] val;
    } nibble_t;

    typedef struct packed {
        logic pre;
        logic dec;
        logic hex;
    } fmt_flags_t;

endpackage

/* hw/rtl/tdip_front.sv */
// ============================================================================
// tdip_front: character classifier stage
// Accepts characters and registers their class bits and digit value.
// ============================================================================
module tdip_front
    import tdip_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  char_code,
    output logic        out_valid,
    input  logic        out_ready,
    output char_class_t out_item
);

    logic        valid_reg;
    char_class_t item_reg;
    char_class_t item_next;
    logic        upper_hex;
    logic        lower_hex;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb
    begin
        upper_hex       = (char_code >= CH_UA) && (char_code <= CH_UF);
        lower_hex       = (char_code >= CH_LA) && (char_code <= CH_LF);
        item_next.term  = (char_code == CH_NUL);
        item_next.blank = (char_code == CH_SPACE) || (char_code == CH_TAB);
        item_next.zero  = (char_code == CH_ZERO);
        item_next.dig   = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
        item_next.hexl  = upper_hex || lower_hex;
        item_next.is_x  = (char_code == CH_UX) || (char_code == CH_LX);
        item_next.is_h  = (char_code == CH_UH) || (char_code == CH_LH);
        item_next.is_d  = (char_code == CH_UD) || (char_code == CH_LD);
        // Letters A-F sit at low nibble 1..6 in both cases, so adding nine gives 10..15.
        if (item_next.dig)
        begin
            item_next.nib = char_code[3:0];
        end
        else if (item_next.hexl)
        begin
            item_next.nib = char_code[3:0] + 4'd9;
        end
        else
        begin
            item_next.nib = 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_next;
        end
    end

endmodule

/* hw/rtl/tdip_queue.sv */
// ============================================================================
// tdip_queue: short queue of classified characters
// Lets the classifier and the recognizer stall independently.
// ============================================================================
module tdip_queue
    import tdip_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  char_class_t in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output char_class_t out_item
);

    char_class_t       entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              push;
    logic              pop;

    assign in_ready  = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

/* hw/rtl/tdip_back.sv */
// ============================================================================
// tdip_back: recognizer and result register
// Runs one recognizer transition per character and emits a result at the
// terminator.
// ============================================================================
module tdip_back
    import tdip_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [1:0]  format_hint,
    input  logic        in_valid,
    output logic        in_ready,
    input  char_class_t in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  status,
    output logic [7:0]  id_value,
    output logic        was_hex,
    output logic        was_dec
);

    typedef enum logic [3:0] {
        ST_BLANK, ST_INIT, ST_ONE_ZERO, ST_PREFIX, ST_AMB1, ST_AMB2,
        ST_DEC1, ST_DEC2, ST_HEX1, ST_HEX2, ST_ZERO2, ST_FULL,
        ST_PRE_HEX, ST_PRE_DEC, ST_PD_ZERO1, ST_PD_ZERO2
    } state_t;

    state_t           state_reg,  state_next;
    logic [CNT_W-1:0] cnt_reg,    cnt_next;
    nibble_t          fn_reg,     fn_next;
    nibble_t          sn_reg,     sn_next;
    fmt_flags_t       flags_reg,  flags_next;
    logic [3:0]       err_reg,    err_next;

    logic             out_valid_reg;
    logic [3:0]       status_reg, status_next;
    logic [7:0]       value_reg,  value_next;
    logic             hex_reg,    hex_next;
    logic             dec_reg,    dec_next;

    logic             emit;
    logic             skip;
    logic             pop;
    logic [3:0]       adv_err;
    logic             xdig;
    logic [3:0]       msd;
    logic [3:0]       lsd;

    // A terminator needs the result register free; other characters never wait.
    assign in_ready  = !in_item.term || !out_valid_reg || out_ready;
    assign pop       = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign id_value  = value_reg;
    assign was_hex   = hex_reg;
    assign was_dec   = dec_reg;
    assign xdig      = in_item.dig || in_item.hexl;

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        fn_next     = fn_reg;
        sn_next     = sn_reg;
        flags_next  = flags_reg;
        err_next    = err_reg;
        emit        = 1'b0;
        skip        = 1'b0;
        adv_err     = STATUS_GOOD;
        status_next = STATUS_GOOD;
        value_next  = 8'd0;
        hex_next    = 1'b0;
        dec_next    = 1'b0;
        msd         = 4'd0;
        lsd         = 4'd0;

        // Blank skipping and format hint sampling.
        if (state_reg == ST_BLANK)
        begin
            if (in_item.term)
            begin
                emit        = 1'b1;
                skip        = 1'b1;
                status_next = STATUS_BLANKS_ONLY;
                hex_next    = (format_hint == HINT_HEX);
                dec_next    = (format_hint == HINT_DEC);
            end
            else if (in_item.blank && (cnt_reg <= CNT_W'(BLANK_LIMIT)))
            begin
                cnt_next = cnt_reg + 1'b1;
                skip     = 1'b1;
            end
            else
            begin
                cnt_next = '0;
                case (format_hint)
                    HINT_HEX:
                    begin
                        flags_next = '{pre: 1'b0, dec: 1'b0, hex: 1'b1};
                        state_next = ST_PRE_HEX;
                    end
                    HINT_DEC:
                    begin
                        flags_next = '{pre: 1'b0, dec: 1'b1, hex: 1'b0};
                        state_next = ST_PRE_DEC;
                    end
                    default:
                    begin
                        flags_next = '0;
                        state_next = ST_INIT;
                    end
                endcase
            end
        end

        if (!skip && !in_item.term)
        begin
            if ((err_reg == STATUS_GOOD) && (cnt_next <= CNT_W'(MAX_LEN)))
            begin
                case (state_next)
                    ST_INIT:
                    begin
                        if (in_item.zero)
                        begin
                            fn_next = '{empty: 1'b0, val: 4'd0};
                            state_next = ST_ONE_ZERO;
                        end
                        else if (xdig)
                        begin
                            if (in_item.dig)
                            begin
                                state_next = ST_AMB1;
                            end
                            else
                            begin
                                flags_next.hex = 1'b1;
                                state_next     = ST_HEX1;
                            end
                            fn_next = '{empty: 1'b0, val: in_item.nib};
                        end
                        else if (in_item.is_x)
                        begin
                            flags_next.hex = 1'b1;
                            flags_next.pre = 1'b1;
                            state_next     = ST_PREFIX;
                        end
                        else
                        begin
                            adv_err = STATUS_BAD_CHAR1;
                        end
                    end
                    ST_ONE_ZERO:
                    begin
                        if (in_item.zero)
                        begin
                            sn_next = '{empty: 1'b0, val: 4'd0};
                            state_next = ST_ZERO2;
                        end
                        else if (in_item.is_x)
                        begin
                            flags_next.hex = 1'b1;
                            flags_next.pre = 1'b1;
                            state_next     = ST_PREFIX;
                        end
                        else if (xdig)
                        begin
                            if (in_item.dig)
                            begin
                                state_next = ST_AMB2;
                            end
                            else
                            begin
                                flags_next.hex = 1'b1;
                                state_next     = ST_HEX2;
                            end
                            fn_next = '{empty: 1'b0, val: in_item.nib};
                        end
                        else if (in_item.is_h)
                        begin
                            flags_next.hex = 1'b1;
                            state_next     = ST_FULL;
                        end
                        else
                        begin
                            adv_err = STATUS_BAD_DIGIT2;
                        end
                    end
                    ST_PREFIX:
                    begin
                        if (xdig)
                        begin
                            fn_next    = '{empty: 1'b0, val: in_item.nib};
                            state_next = ST_HEX1;
                        end
                        else
                        begin
                            adv_err = STATUS_BAD_DIGIT1;
                        end
                    end
                    ST_AMB1:
                    begin
                        if (xdig)
                        begin
                            if (in_item.dig)
                            begin
                                state_next = ST_AMB2;
                            end
                            else
                            begin
                                flags_next.hex = 1'b1;
                                state_next     = ST_HEX2;
                            end
                            sn_next = '{empty: 1'b0, val: in_item.nib};
                        end
                        else if (in_item.is_x || in_item.is_h)
                        begin
                            flags_next.hex = 1'b1;
                            state_next     = ST_FULL;
                        end
                        else
                        begin
                            adv_err = STATUS_BAD_DIGIT2;
                        end
                    end
                    ST_AMB2:
                    begin
                        if (in_item.is_x || in_item.is_h)
                        begin
                            flags_next.hex = 1'b1;
                            state_next     = ST_FULL;
                        end
                        else if (in_item.is_d)
                        begin
                            flags_next.dec = 1'b1;
                            state_next     = ST_FULL;
                        end
                        else
                        begin
                            adv_err = STATUS_TOO_MANY;
                        end
                    end
                    ST_DEC1:
                    begin
                        if (in_item.dig)
                        begin
                            sn_next    = '{empty: 1'b0, val: in_item.nib};
                            state_next = ST_DEC2;
                        end
                        else
                        begin
                            adv_err = STATUS_BAD_DIGIT2;
                        end
                    end
                    ST_DEC2:
                    begin
                        if (in_item.is_d)
                        begin
                            state_next = ST_FULL;
                        end
                        else
                        begin
                            adv_err = STATUS_BAD_SUFFIX;
                        end
                    end
                    ST_HEX1:
                    begin
                        if (xdig)
                        begin
                            sn_next    = '{empty: 1'b0, val: in_item.nib};
                            state_next = ST_HEX2;
                        end
                        else if (in_item.is_x || in_item.is_h)
                        begin
                            if (flags_next.pre)
                            begin
                                adv_err = STATUS_PRE_AND_SUF;
                            end
                            else
                            begin
                                flags_next.hex = 1'b1;
                                state_next     = ST_FULL;
                            end
                        end
                        else
                        begin
                            adv_err = STATUS_BAD_DIGIT2;
                        end
                    end
                    ST_HEX2:
                    begin
                        if (in_item.is_x || in_item.is_h)
                        begin
                            state_next = ST_FULL;
                        end
                        else
                        begin
                            adv_err = STATUS_BAD_SUFFIX;
                        end
                    end
                    ST_ZERO2:
                    begin
                        if (!flags_next.dec && (in_item.is_x || in_item.is_h))
                        begin
                            flags_next.hex = 1'b1;
                            state_next     = ST_FULL;
                        end
                        else if (!flags_next.hex && in_item.is_d)
                        begin
                            flags_next.dec = 1'b1;
                            state_next     = ST_FULL;
                        end
                        else
                        begin
                            adv_err = STATUS_TOO_MANY;
                        end
                    end
                    ST_FULL:
                    begin
                        adv_err = STATUS_TOO_MANY;
                    end
                    ST_PRE_HEX:
                    begin
                        if (in_item.is_x)
                        begin
                            flags_next.pre = 1'b1;
                            state_next     = ST_PREFIX;
                        end
                        else if (in_item.zero)
                        begin
                            fn_next    = '{empty: 1'b0, val: 4'd0};
                            state_next = ST_ONE_ZERO;
                        end
                        else if (xdig)
                        begin
                            fn_next    = '{empty: 1'b0, val: in_item.nib};
                            state_next = ST_HEX1;
                        end
                        else
                        begin
                            adv_err = STATUS_BAD_CHAR1;
                        end
                    end
                    ST_PRE_DEC:
                    begin
                        if (in_item.is_x || in_item.hexl)
                        begin
                            adv_err = STATUS_HEX_DEC1;
                        end
                        else if (in_item.zero)
                        begin
                            fn_next    = '{empty: 1'b0, val: 4'd0};
                            state_next = ST_PD_ZERO1;
                        end
                        else if (in_item.dig)
                        begin
                            fn_next    = '{empty: 1'b0, val: in_item.nib};
                            state_next = ST_DEC1;
                        end
                        else
                        begin
                            adv_err = STATUS_BAD_CHAR1;
                        end
                    end
                    ST_PD_ZERO1:
                    begin
                        if (in_item.is_x || in_item.hexl)
                        begin
                            adv_err = STATUS_HEX_DEC2;
                        end
                        else if (in_item.zero)
                        begin
                            state_next = ST_PD_ZERO2;
                        end
                        else if (in_item.dig)
                        begin
                            fn_next    = '{empty: 1'b0, val: in_item.nib};
                            state_next = ST_DEC2;
                        end
                        else
                        begin
                            adv_err = STATUS_BAD_CHAR2;
                        end
                    end
                    ST_PD_ZERO2:
                    begin
                        if (in_item.is_d)
                        begin
                            state_next = ST_FULL;
                        end
                        else
                        begin
                            adv_err = STATUS_BAD_SUFFIX;
                        end
                    end
                    default:
                    begin
                        adv_err = STATUS_GOOD;
                    end
                endcase
                err_next = adv_err;
                if (adv_err == STATUS_GOOD)
                begin
                    cnt_next = cnt_next + 1'b1;
                end
            end
        end
        else if (!skip)
        begin
            // Terminator after at least one recognizer character.
            emit     = 1'b1;
            hex_next = flags_next.hex;
            dec_next = flags_next.dec;
            if (sn_next.empty)
            begin
                msd = 4'd0;
                lsd = fn_next.val;
            end
            else
            begin
                msd = fn_next.val;
                lsd = sn_next.val;
            end
            if (cnt_next >= CNT_W'(MAX_LEN))
            begin
                status_next = STATUS_TOO_MANY;
            end
            else if (err_next != STATUS_GOOD)
            begin
                status_next = err_next;
            end
            else if ((flags_next.hex || flags_next.dec) && fn_next.empty && sn_next.empty)
            begin
                status_next = STATUS_NO_DIGITS;
            end
            else if (flags_next.hex || !flags_next.dec)
            begin
                value_next = {msd, lsd};
            end
            else
            begin
                value_next = ({4'd0, msd} * 8'd10) + {4'd0, lsd};
            end
        end

        // Every terminator returns the recognizer to its start state.
        if (emit)
        begin
            state_next = ST_BLANK;
            cnt_next   = '0;
            fn_next    = '{empty: 1'b1, val: 4'd0};
            sn_next    = '{empty: 1'b1, val: 4'd0};
            flags_next = '0;
            err_next   = STATUS_GOOD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_BLANK;
            cnt_reg       <= '0;
            fn_reg        <= '{empty: 1'b1, val: 4'd0};
            sn_reg        <= '{empty: 1'b1, val: 4'd0};
            flags_reg     <= '0;
            err_reg       <= STATUS_GOOD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                state_reg <= state_next;
                cnt_reg   <= cnt_next;
                fn_reg    <= fn_next;
                sn_reg    <= sn_next;
                flags_reg <= flags_next;
                err_reg   <= err_next;
            end
            if (pop && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && emit)
        begin
            status_reg <= status_next;
            value_reg  <= value_next;
            hex_reg    <= hex_next;
            dec_reg    <= dec_next;
        end
    end

    // A terminator always produces a result in the following cycle.
    a_term_emits: assert property (@(posedge clk) disable iff (!rst_n)
        pop && in_item.term |=> out_valid_reg)
        else $error("terminator did not produce a result");

    // A terminator leaves the recognizer clean for the next string.
    a_term_clears: assert property (@(posedge clk) disable iff (!rst_n)
        pop && in_item.term |=> (state_reg == ST_BLANK) && (cnt_reg == '0)
                                && (err_reg == STATUS_GOOD))
        else $error("recognizer not cleared after terminator");

    // A latched error only exists while a string is in the recognizer.
    a_err_state: assert property (@(posedge clk) disable iff (!rst_n)
        (err_reg != STATUS_GOOD) |-> (state_reg != ST_BLANK))
        else $error("error latched in blank skipping state");

    // Only a good status carries a value.
    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (status_reg != STATUS_GOOD) |-> (value_reg == 8'd0))
        else $error("nonzero value with error status");

endmodule

/* hw/rtl/two_digit_id_text_parser.sv */
// ============================================================================
// two_digit_id_text_parser: one- or two-digit ID text parser
// Reads a zero-terminated ASCII string and reports status, value and format.
// ============================================================================
// Usage:
// Characters arrive one per transaction on the slave stream (s_tdata[7:0]).
// A zero code terminates the string. Leading blanks are skipped, then one or
// two hex or decimal digits with an optional x prefix or an x, h or d suffix
// are recognized under the hint held in the format register (cfg_we with
// cfg_wdata; change it only while the block is idle). Each terminator yields
// exactly one transaction on the master stream carrying the status and the
// 8-bit value in m_tdata and the final hex and decimal flags in m_tuser.
// Throughput is one character per cycle unless a stage stalls, through a
// classifier register, a two-entry queue and the recognizer, with the result
// held in an output register so the next string keeps flowing while it waits.
// A terminator passes the classifier register and the queue before its result
// is registered. When the receiver stalls, only a second terminator waits;
// the queue then fills and s_tready drops. Reset clears the recognizer, the
// queue and the output valid, and sets the hint to free format.
// ============================================================================
module two_digit_id_text_parser
    import tdip_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration: format hint register.
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,
    // Slave stream of characters.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    // Master stream of results.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [3:0] status, [11:4] id_value, [15:12] zero
    output logic [1:0]  m_tuser    // [0] was_hex, [1] was_dec
);

    logic [1:0]  hint_reg;

    logic        front_valid;
    logic        front_ready;
    char_class_t front_item;
    logic        queue_valid;
    logic        queue_ready;
    char_class_t queue_item;

    logic [3:0]  status;
    logic [7:0]  id_value;
    logic        was_hex;
    logic        was_dec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hint_reg <= HINT_FREE;
        end
        else if (cfg_we)
        begin
            hint_reg <= cfg_wdata;
        end
    end

    tdip_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .char_code (s_tdata),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_item  (front_item)
    );

    tdip_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_item   (front_item),
        .out_valid (queue_valid),
        .out_ready (queue_ready),
        .out_item  (queue_item)
    );

    tdip_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .format_hint (hint_reg),
        .in_valid    (queue_valid),
        .in_ready    (queue_ready),
        .in_item     (queue_item),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .status      (status),
        .id_value    (id_value),
        .was_hex     (was_hex),
        .was_dec     (was_dec)
    );

    assign m_tdata = {4'd0, id_value, status};
    assign m_tuser = {was_dec, was_hex};

endmodule

/* verif/two_digit_id_text_parser_tb.sv */
// ============================================================================
// two_digit_id_text_parser_tb: self-checking testbench of the ID text parser
// Streams zero-terminated strings into the parser and compares every result
// transaction against a cycle-free model of the recognizer, held in this file,
// under all format hints, with random gaps and stalls on both streams.
// ============================================================================
module two_digit_id_text_parser_tb;
    import tdip_pkg::*;

    // The fourth hint code has no name in the package; the block treats it
    // as free format.
    localparam logic [1:0] HINT_ODD = 2'd3;
    localparam logic [7:0] CH_ONE_AFTER_ZERO = CH_ZERO + 8'd1;

    // Cycles that a character may still spend inside the pipeline after the
    // last result has left: classifier, queue, recognizer and output stage.
    localparam int PIPE_SETTLE = 8;
    localparam int CYCLE_LIMIT = 250000;
    localparam int END_WAIT    = 2000;

    // States of the recognizer as this testbench models it.
    typedef enum logic [3:0] {
        PS_BLANK, PS_INIT, PS_ONE_ZERO, PS_PREFIX, PS_AMB1, PS_AMB2,
        PS_DEC1, PS_DEC2, PS_HEX1, PS_HEX2, PS_ZERO2, PS_FULL,
        PS_PRE_HEX, PS_PRE_DEC, PS_PD_ZERO1, PS_PD_ZERO2
    } parse_state_t;

    // One result transaction, field by field.
    typedef struct packed {
        logic [3:0] status;
        logic [7:0] id_value;
        logic       was_hex;
        logic       was_dec;
    } id_result_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_wdata = 2'd0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'd0;   // [7:0] char_code
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;            // [3:0] status, [11:4] id_value, [15:12] zero
    logic [1:0]  m_tuser;            // [0] was_hex, [1] was_dec

    // Results that the model has computed and the block has not yet sent.
    id_result_t  pending_ids[$];
    id_result_t  want_id;

    // Model state of the parser.
    logic [1:0]   hint_now;
    parse_state_t parse_st;
    int           run_len;
    nibble_t      lead_nib;
    nibble_t      tail_nib;
    fmt_flags_t   fmt;
    logic [3:0]   err_latch;

    int  mismatches  = 0;
    int  chars_sent  = 0;
    int  cycle_count = 0;
    int  ready_wait  = 0;
    // When set, the side concerned runs without any idle cycles.
    bit  send_steady = 1'b0;
    bit  recv_steady = 1'b0;

    two_digit_id_text_parser uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Character classes, written out from the ASCII table.
    // ------------------------------------------------------------------------
    function automatic bit is_dec_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic bit is_hex_digit(input logic [7:0] c);
        return is_dec_digit(c) || (c >= CH_UA && c <= CH_UF) || (c >= CH_LA && c <= CH_LF);
    endfunction

    function automatic bit is_hex_letter(input logic [7:0] c);
        return is_hex_digit(c) && !is_dec_digit(c);
    endfunction

    function automatic bit is_x_mark(input logic [7:0] c);
        return c == CH_UX || c == CH_LX;
    endfunction

    function automatic bit is_h_mark(input logic [7:0] c);
        return c == CH_UH || c == CH_LH;
    endfunction

    function automatic bit is_d_mark(input logic [7:0] c);
        return c == CH_UD || c == CH_LD;
    endfunction

    function automatic logic [3:0] nibble_value(input logic [7:0] c);
        if (is_dec_digit(c))
            return 4'(c - CH_ZERO);
        if (c >= CH_UA && c <= CH_UF)
            return 4'(10 + (c - CH_UA));
        if (c >= CH_LA && c <= CH_LF)
            return 4'(10 + (c - CH_LA));
        return 4'd0;
    endfunction

    // Back to the state of a fresh string; the hint is kept.
    function automatic void clear_parse();
        parse_st  = PS_BLANK;
        run_len   = 0;
        lead_nib  = {1'b1, 4'd0};
        tail_nib  = {1'b1, 4'd0};
        fmt       = '0;
        err_latch = STATUS_GOOD;
    endfunction

    // One step of the recognizer. An error leaves the state untouched and is
    // returned to be latched by the caller.
    function automatic logic [3:0] parse_char(input logic [7:0] c);
        parse_state_t nxt;
        nxt = parse_st;
        case (parse_st)
            PS_INIT:
            begin
                if (c == CH_ZERO)
                begin
                    lead_nib = {1'b0, 4'd0};
                    nxt = PS_ONE_ZERO;
                end
                else if (is_hex_digit(c))
                begin
                    if (is_dec_digit(c))
                        nxt = PS_AMB1;
                    else
                    begin
                        fmt.hex = 1'b1;
                        nxt = PS_HEX1;
                    end
                    lead_nib = {1'b0, nibble_value(c)};
                end
                else if (is_x_mark(c))
                begin
                    fmt.hex = 1'b1;
                    fmt.pre = 1'b1;
                    nxt = PS_PREFIX;
                end
                else
                    return STATUS_BAD_CHAR1;
            end
            PS_ONE_ZERO:
            begin
                if (c == CH_ZERO)
                begin
                    tail_nib = {1'b0, 4'd0};
                    nxt = PS_ZERO2;
                end
                else if (is_x_mark(c))
                begin
                    fmt.hex = 1'b1;
                    fmt.pre = 1'b1;
                    nxt = PS_PREFIX;
                end
                else if (is_hex_digit(c))
                begin
                    // The leading zero is dropped: the new digit is the first.
                    if (is_dec_digit(c))
                        nxt = PS_AMB2;
                    else
                    begin
                        fmt.hex = 1'b1;
                        nxt = PS_HEX2;
                    end
                    lead_nib = {1'b0, nibble_value(c)};
                end
                else if (is_h_mark(c))
                begin
                    fmt.hex = 1'b1;
                    nxt = PS_FULL;
                end
                else
                    return STATUS_BAD_DIGIT2;
            end
            PS_PREFIX:
            begin
                if (is_hex_digit(c))
                begin
                    lead_nib = {1'b0, nibble_value(c)};
                    nxt = PS_HEX1;
                end
                else
                    return STATUS_BAD_DIGIT1;
            end
            PS_AMB1:
            begin
                if (is_hex_digit(c))
                begin
                    if (is_dec_digit(c))
                        nxt = PS_AMB2;
                    else
                    begin
                        fmt.hex = 1'b1;
                        nxt = PS_HEX2;
                    end
                    tail_nib = {1'b0, nibble_value(c)};
                end
                else if (is_x_mark(c) || is_h_mark(c))
                begin
                    fmt.hex = 1'b1;
                    nxt = PS_FULL;
                end
                else
                    return STATUS_BAD_DIGIT2;
            end
            PS_AMB2:
            begin
                if (is_x_mark(c) || is_h_mark(c))
                begin
                    fmt.hex = 1'b1;
                    nxt = PS_FULL;
                end
                else if (is_d_mark(c))
                begin
                    fmt.dec = 1'b1;
                    nxt = PS_FULL;
                end
                else
                    return STATUS_TOO_MANY;
            end
            PS_DEC1:
            begin
                if (is_dec_digit(c))
                begin
                    tail_nib = {1'b0, nibble_value(c)};
                    nxt = PS_DEC2;
                end
                else
                    return STATUS_BAD_DIGIT2;
            end
            PS_DEC2:
            begin
                if (is_d_mark(c))
                    nxt = PS_FULL;
                else
                    return STATUS_BAD_SUFFIX;
            end
            PS_HEX1:
            begin
                if (is_hex_digit(c))
                begin
                    tail_nib = {1'b0, nibble_value(c)};
                    nxt = PS_HEX2;
                end
                else if (is_x_mark(c) || is_h_mark(c))
                begin
                    if (fmt.pre)
                        return STATUS_PRE_AND_SUF;
                    fmt.hex = 1'b1;
                    nxt = PS_FULL;
                end
                else
                    return STATUS_BAD_DIGIT2;
            end
            PS_HEX2:
            begin
                if (is_x_mark(c) || is_h_mark(c))
                    nxt = PS_FULL;
                else
                    return STATUS_BAD_SUFFIX;
            end
            PS_ZERO2:
            begin
                if (!fmt.dec && (is_x_mark(c) || is_h_mark(c)))
                begin
                    fmt.hex = 1'b1;
                    nxt = PS_FULL;
                end
                else if (!fmt.hex && is_d_mark(c))
                begin
                    fmt.dec = 1'b1;
                    nxt = PS_FULL;
                end
                else
                    return STATUS_TOO_MANY;
            end
            PS_FULL:
                return STATUS_TOO_MANY;
            PS_PRE_HEX:
            begin
                if (is_x_mark(c))
                begin
                    fmt.pre = 1'b1;
                    nxt = PS_PREFIX;
                end
                else if (c == CH_ZERO)
                begin
                    lead_nib = {1'b0, 4'd0};
                    nxt = PS_ONE_ZERO;
                end
                else if (is_hex_digit(c))
                begin
                    lead_nib = {1'b0, nibble_value(c)};
                    nxt = PS_HEX1;
                end
                else
                    return STATUS_BAD_CHAR1;
            end
            PS_PRE_DEC:
            begin
                if (is_x_mark(c) || is_hex_letter(c))
                    return STATUS_HEX_DEC1;
                else if (c == CH_ZERO)
                begin
                    lead_nib = {1'b0, 4'd0};
                    nxt = PS_PD_ZERO1;
                end
                else if (is_dec_digit(c))
                begin
                    lead_nib = {1'b0, nibble_value(c)};
                    nxt = PS_DEC1;
                end
                else
                    return STATUS_BAD_CHAR1;
            end
            PS_PD_ZERO1:
            begin
                if (is_x_mark(c) || is_hex_letter(c))
                    return STATUS_HEX_DEC2;
                else if (c == CH_ZERO)
                    nxt = PS_PD_ZERO2;
                else if (is_dec_digit(c))
                begin
                    lead_nib = {1'b0, nibble_value(c)};
                    nxt = PS_DEC2;
                end
                else
                    return STATUS_BAD_CHAR2;
            end
            PS_PD_ZERO2:
            begin
                if (is_d_mark(c))
                    nxt = PS_FULL;
                else
                    return STATUS_BAD_SUFFIX;
            end
            default:
                nxt = parse_st;
        endcase
        parse_st = nxt;
        return STATUS_GOOD;
    endfunction

    // Applies one accepted character to the model; a terminator queues the
    // result that the block must send for the string.
    function automatic void predict_char(input logic [7:0] c);
        id_result_t r;
        logic [3:0] msd;
        logic [3:0] lsd;
        r = '0;
        if (parse_st == PS_BLANK)
        begin
            if (c == CH_NUL)
            begin
                r.status  = STATUS_BLANKS_ONLY;
                r.was_hex = (hint_now == HINT_HEX);
                r.was_dec = (hint_now == HINT_DEC);
                pending_ids.push_back(r);
                clear_parse();
                return;
            end
            // Only a bounded run of blanks is skipped; the next blank goes
            // to the recognizer like any other bad character.
            if ((c == CH_SPACE || c == CH_TAB) && run_len <= BLANK_LIMIT)
            begin
                run_len++;
                return;
            end
            run_len = 0;
            if (hint_now == HINT_HEX)
            begin
                fmt = '0;
                fmt.hex = 1'b1;
                parse_st = PS_PRE_HEX;
            end
            else if (hint_now == HINT_DEC)
            begin
                fmt = '0;
                fmt.dec = 1'b1;
                parse_st = PS_PRE_DEC;
            end
            else
            begin
                fmt = '0;
                parse_st = PS_INIT;
            end
        end
        if (c != CH_NUL)
        begin
            if (err_latch == STATUS_GOOD && run_len <= MAX_LEN)
            begin
                err_latch = parse_char(c);
                if (err_latch == STATUS_GOOD)
                    run_len++;
            end
            return;
        end
        r.was_hex = fmt.hex;
        r.was_dec = fmt.dec;
        // The length check wins even over an error latched earlier.
        if (run_len >= MAX_LEN)
            r.status = STATUS_TOO_MANY;
        else if (err_latch != STATUS_GOOD)
            r.status = err_latch;
        else if ((fmt.hex || fmt.dec) && lead_nib.empty && tail_nib.empty)
            r.status = STATUS_NO_DIGITS;
        else
        begin
            r.status = STATUS_GOOD;
            if (tail_nib.empty)
            begin
                msd = 4'd0;
                lsd = lead_nib.val;
            end
            else
            begin
                msd = lead_nib.val;
                lsd = tail_nib.val;
            end
            // Both flags set reads the digits as hex.
            if (fmt.hex || !fmt.dec)
                r.id_value = {msd, lsd};
            else
                r.id_value = 8'(msd * 10 + lsd);
        end
        pending_ids.push_back(r);
        clear_parse();
    endfunction

    // ------------------------------------------------------------------------
    // Reporting and the result side.
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int want, input int got);
        $display("[%0d] mismatch on %s: expected %0d, got %0d", cycle_count, what, want, got);
        mismatches++;
    endtask

    // Checks every result transaction and draws the receiver's stalls. Values
    // are sampled right at the edge, before any register of the block moves.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("two_digit_id_text_parser regression: fail");
            $finish;
        end
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_ids.size() == 0)
                    report_mismatch("result with nothing pending", -1, int'(m_tdata));
                else
                begin
                    want_id = pending_ids.pop_front();
                    if (m_tdata[3:0] !== want_id.status)
                        report_mismatch("status", int'(want_id.status),
                                        int'(m_tdata[3:0]));
                    if (m_tdata[11:4] !== want_id.id_value)
                        report_mismatch("id_value", int'(want_id.id_value),
                                        int'(m_tdata[11:4]));
                    if (m_tdata[15:12] !== 4'd0)
                        report_mismatch("tdata padding", 0, int'(m_tdata[15:12]));
                    if (m_tuser[0] !== want_id.was_hex)
                        report_mismatch("was_hex", int'(want_id.was_hex), int'(m_tuser[0]));
                    if (m_tuser[1] !== want_id.was_dec)
                        report_mismatch("was_dec", int'(want_id.was_dec), int'(m_tuser[1]));
                end
                ready_wait = recv_steady ? 0 : $urandom_range(0, 4);
            end
            if (ready_wait > 0)
            begin
                ready_wait--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------

    // Sends one character transaction after a random gap and feeds the model
    // once the block has taken it. tvalid is left high so that a following
    // character without a gap keeps the stream busy.
    task automatic send_char(input logic [7:0] c);
        int gap;
        gap = send_steady ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        do
            @(posedge clk);
        while (!s_tready);
        predict_char(c);
        chars_sent++;
    endtask

    task automatic send_text(input string text);
        for (int i = 0; i < text.len(); i++)
            send_char(text[i]);
        send_char(CH_NUL);
    endtask

    // Stops the sender until every queued result has come back, then lets
    // the pipeline run empty.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_ids.size() != 0);
        repeat (PIPE_SETTLE) @(posedge clk);
    endtask

    // Writes the format hint; only called while the block is idle.
    task automatic write_hint(input logic [1:0] hint);
        cfg_we    <= 1'b1;
        cfg_wdata <= hint;
        @(posedge clk);
        cfg_we   <= 1'b0;
        hint_now = hint;
    endtask

    function automatic logic [7:0] pick_digit();
        case ($urandom_range(0, 3))
            0:       return CH_UA + 8'($urandom_range(0, 5));
            1:       return CH_LA + 8'($urandom_range(0, 5));
            default: return CH_ZERO + 8'($urandom_range(0, 9));
        endcase
    endfunction

    function automatic logic [7:0] pick_suffix();
        case ($urandom_range(0, 5))
            0:       return CH_UX;
            1:       return CH_LX;
            2:       return CH_UH;
            3:       return CH_LH;
            4:       return CH_UD;
            default: return CH_LD;
        endcase
    endfunction

    function automatic logic [7:0] pick_blank();
        return $urandom_range(0, 3) == 0 ? CH_TAB : CH_SPACE;
    endfunction

    // Most strings follow the shape the recognizer expects (blanks, a prefix,
    // up to two digits, a suffix) with random content; the rest are noise
    // drawn from the whole nonzero code range.
    task automatic send_random_string();
        int blanks;
        int ndig;
        blanks = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 13) : $urandom_range(0, 2);
        if ($urandom_range(0, 9) < 7)
        begin
            for (int i = 0; i < blanks; i++)
                send_char(pick_blank());
            case ($urandom_range(0, 3))
                1:
                begin
                    send_char(CH_ZERO);
                    send_char($urandom_range(0, 1) ? CH_UX : CH_LX);
                end
                2:       send_char($urandom_range(0, 1) ? CH_UX : CH_LX);
                3:       send_char(CH_ZERO);
                default: ;
            endcase
            ndig = $urandom_range(0, 2);
            for (int i = 0; i < ndig; i++)
                send_char(pick_digit());
            if ($urandom_range(0, 2) != 0)
                send_char(pick_suffix());
        end
        else
        begin
            ndig = $urandom_range(0, 7);
            for (int i = 0; i < ndig; i++)
                case ($urandom_range(0, 3))
                    0:       send_char(pick_digit());
                    1:       send_char(pick_suffix());
                    2:       send_char(pick_blank());
                    default: send_char(8'($urandom_range(1, 255)));
                endcase
        end
        send_char(CH_NUL);
    endtask

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Free format straight out of reset: plain, prefixed and suffixed forms, each
    // free-format error but NO_DIGITS in its own string, the run and blank limits.
    task automatic test_free_format();
        send_text("7");
        send_text("42");
        send_text("0x1F");
        send_text("x9");
        send_text("Ab");
        send_text("1fh");
        send_text("12x");
        send_text("09");
        send_text("00h");
        send_text("00d");
        send_text("0x12h");
        send_text("0x12");
        send_text("G");
        send_text("1G");
        send_text("xZ");
        send_text("x1h");
        send_text("1fz");
        send_text("255");
        send_text("");
        send_text(" \t 3");
        // Eleven blanks are still skipped, a twelfth one is a bad character.
        send_text("           5");
        send_text("            5");
        // Codes with the top bit set belong to no class.
        send_char(8'hFF);
        send_char(CH_NUL);
        send_char(CH_ONE_AFTER_ZERO);
        send_char(8'h80);
        send_char(CH_NUL);
        drain_results();
    endtask

    // Hex hint: blanks-only flags, a lone prefix without digits, and a
    // leading zero with a decimal suffix that sets both flags.
    task automatic test_hex_hint();
        write_hint(HINT_HEX);
        send_text("");
        send_text("   ");
        send_text("x");
        send_text("0");
        send_text("01d");
        send_text("Fh");
        send_text("0x5");
        send_text("xx");
        send_text("0Xah");
        send_text("7f");
        drain_results();
    endtask

    // Decimal hint: hex characters in the first and second place, the zero
    // paths and the decimal suffix.
    task automatic test_dec_hint();
        write_hint(HINT_DEC);
        send_text("");
        send_text("a");
        send_text("x");
        send_text("0a");
        send_text("0");
        send_text("00d");
        send_text("00");
        send_text("07");
        send_text("59d");
        send_text("59");
        send_text("0:");
        send_text("!");
        send_text("5x");
        drain_results();
    endtask

    // The unused hint code behaves as free format.
    task automatic test_odd_hint();
        write_hint(HINT_ODD);
        send_text("3Ah");
        send_text("Dd");
        send_text("");
        drain_results();
    endtask

    // Terminators back to back with no gaps from the sender, first against a
    // stalling receiver so that the queue fills, then with both sides busy.
    task automatic test_back_to_back();
        write_hint(HINT_FREE);
        send_steady = 1'b1;
        for (int i = 0; i < 30; i++)
            send_char(CH_NUL);
        for (int i = 0; i < 30; i++)
            send_random_string();
        recv_steady = 1'b1;
        for (int i = 0; i < 30; i++)
            send_random_string();
        for (int i = 0; i < 20; i++)
            send_char(CH_NUL);
        drain_results();
        send_steady = 1'b0;
        recv_steady = 1'b0;
    endtask

    // Random strings in segments, each under its own hint. Now and then the
    // sender holds off until all results are back, and now and then one side
    // runs without gaps for a while.
    task automatic test_random_strings();
        logic [1:0] hint;
        int         stop_at;
        for (int seg = 0; seg < 8; seg++)
        begin
            case (seg)
                0:       hint = HINT_FREE;
                1:       hint = HINT_ODD;
                2:       hint = HINT_HEX;
                3:       hint = HINT_DEC;
                default: hint = 2'($urandom_range(0, 3));
            endcase
            write_hint(hint);
            stop_at = chars_sent + 200;
            while (chars_sent < stop_at)
            begin
                send_random_string();
                if ($urandom_range(0, 49) == 0)
                    drain_results();
                if ($urandom_range(0, 15) == 0)
                    send_steady = !send_steady;
                if ($urandom_range(0, 15) == 0)
                    recv_steady = !recv_steady;
            end
            drain_results();
        end
        send_steady = 1'b0;
        recv_steady = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Sequence of the run.
    // ------------------------------------------------------------------------
    initial
    begin
        int waited;
        hint_now = HINT_FREE;
        clear_parse();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_free_format();
        test_hex_hint();
        test_dec_hint();
        test_odd_hint();
        test_back_to_back();
        test_random_strings();

        // Every character has been taken; wait for the last results, bounded.
        s_tvalid <= 1'b0;
        waited = 0;
        while (pending_ids.size() != 0 && waited < END_WAIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (PIPE_SETTLE) @(posedge clk);
        if (pending_ids.size() != 0)
            report_mismatch("results never sent", 0, pending_ids.size());

        if (mismatches == 0)
            $display("two_digit_id_text_parser regression: pass");
        else
            $display("two_digit_id_text_parser regression: fail");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/tdip_pkg.sv
hw/rtl/tdip_front.sv
hw/rtl/tdip_queue.sv
hw/rtl/tdip_back.sv
hw/rtl/two_digit_id_text_parser.sv
verif/two_digit_id_text_parser_tb.sv
